/* design/lkv_pkg.sv */
// Package: sizes, codes and shared types of the linear key/value table.
`default_nettype none
package lkv_pkg;

	// Table size and stored value width
	localparam int CAPACITY   = 32;
	localparam int VALUE_BITS = 32;

	// Port widths fixed by the interface
	localparam int OP_W     = 2;
	localparam int KEY_W    = 64;
	localparam int VAL_IN_W = 32;
	localparam int STATUS_W = 2;
	localparam int ENTRIES_W = 6;

	// Derived widths
	localparam int STORE_W = (VALUE_BITS < VAL_IN_W) ? VALUE_BITS : VAL_IN_W;
	localparam int IDX_W   = $clog2(CAPACITY);
	localparam int CNT_W   = $clog2(CAPACITY + 1);

	// Operation codes
	localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
	localparam logic [OP_W-1:0] OP_GET    = 2'd1;
	localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;
	localparam logic [OP_W-1:0] OP_NOP    = 2'd3;

	// Status codes
	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_DUPLICATE = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

	// Search token handed from cell to cell
	typedef struct packed {
		logic [KEY_W-1:0]   key;
		logic               hit;
		logic [IDX_W-1:0]   slot;
		logic [STORE_W-1:0] hit_val;
		logic [KEY_W-1:0]   last_key;
		logic [STORE_W-1:0] last_val;
	} pkt_t;

	// Write broadcast to the cells
	typedef struct packed {
		logic               en;
		logic [IDX_W-1:0]   slot;
		logic [KEY_W-1:0]   key;
		logic [STORE_W-1:0] val;
	} wr_t;

endpackage
`default_nettype wire

/* design/lkv_cell.sv */
// One table slot: holds a key/value pair and passes the search token on.
`default_nettype none
module lkv_cell (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic [lkv_pkg::IDX_W-1:0] cell_idx,
	input  wire logic [lkv_pkg::CNT_W-1:0] count,
	input  wire lkv_pkg::wr_t              wr,
	input  wire logic                      in_vld,
	input  wire lkv_pkg::pkt_t             in_pkt,
	output logic                           out_vld,
	output lkv_pkg::pkt_t                  out_pkt
);

	logic [lkv_pkg::KEY_W-1:0]   key_q;
	logic [lkv_pkg::STORE_W-1:0] val_q;
	logic                        vld_q;
	lkv_pkg::pkt_t               pkt_q;
	lkv_pkg::pkt_t               pkt_nxt;
	logic                        active;
	logic                        is_last;

	// Slot is occupied when below the fill count
	assign active  = lkv_pkg::CNT_W'(cell_idx) < count;
	assign is_last = (lkv_pkg::CNT_W'(cell_idx) + lkv_pkg::CNT_W'(1)) == count;

	// Update the token: first match wins, last occupied slot is captured
	always_comb begin
		pkt_nxt = in_pkt;
		if (active && !in_pkt.hit && key_q == in_pkt.key) begin
			pkt_nxt.hit     = 1'b1;
			pkt_nxt.slot    = cell_idx;
			pkt_nxt.hit_val = val_q;
		end
		if (is_last) begin
			pkt_nxt.last_key = key_q;
			pkt_nxt.last_val = val_q;
		end
	end

	// Token valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= in_vld;
		end
	end

	// Token payload
	always_ff @(posedge clk) begin
		pkt_q <= pkt_nxt;
	end

	// Stored pair, written by broadcast
	always_ff @(posedge clk) begin
		if (wr.en && wr.slot == cell_idx) begin
			key_q <= wr.key;
			val_q <= wr.val;
		end
	end

	assign out_vld = vld_q;
	assign out_pkt = pkt_q;

endmodule
`default_nettype wire

/* design/linear_key_value_table_top.sv */
// Top level: chain of table cells, search sequencing, write-back and result register.
// Each beat's search token walks the cell chain one slot per cycle; the token is then
// captured, and the result register and write-back are loaded together once the
// output slot is free. A new beat is stalled until the previous one has finished.
// Reset clears the entry count and control; stored pairs are undefined until
// written and need no clearing.
`default_nettype none
module linear_key_value_table_top (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic [lkv_pkg::OP_W-1:0]     operation,
	input  wire logic [lkv_pkg::KEY_W-1:0]    lookup_key,
	input  wire logic [lkv_pkg::VAL_IN_W-1:0] entry_value,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic [lkv_pkg::STATUS_W-1:0]      status,
	output logic [lkv_pkg::VAL_IN_W-1:0]      found_value,
	output logic [lkv_pkg::ENTRIES_W-1:0]     entries_used
);

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_SEARCH = 2'd1;
	localparam logic [1:0] S_FINISH = 2'd2;

	logic [1:0]                  state_q;
	logic [lkv_pkg::CNT_W-1:0]   count_q;
	logic [lkv_pkg::OP_W-1:0]    op_q;
	logic [lkv_pkg::STORE_W-1:0] add_val_q;
	lkv_pkg::pkt_t               done_q;
	logic                        out_valid_q;
	logic [lkv_pkg::STATUS_W-1:0] status_q;
	logic [lkv_pkg::STORE_W-1:0] found_q;

	logic                        accept;
	logic                        out_free;
	logic                        finish;
	lkv_pkg::wr_t                wr;
	logic [lkv_pkg::CNT_W-1:0]   count_nxt;
	logic [lkv_pkg::STATUS_W-1:0] status_nxt;
	logic [lkv_pkg::STORE_W-1:0] found_nxt;

	logic                        chain_vld [lkv_pkg::CAPACITY+1];
	lkv_pkg::pkt_t               chain_pkt [lkv_pkg::CAPACITY+1];

	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign finish   = (state_q == S_FINISH) && out_free;

	// Token injected at the head of the chain
	always_comb begin
		chain_vld[0]          = accept;
		chain_pkt[0]          = '0;
		chain_pkt[0].key      = lookup_key;
	end

	// Row of cells
	for (genvar i = 0; i < lkv_pkg::CAPACITY; i++) begin : g_cell
		lkv_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cell_idx (lkv_pkg::IDX_W'(i)),
			.count    (count_q),
			.wr       (wr),
			.in_vld   (chain_vld[i]),
			.in_pkt   (chain_pkt[i]),
			.out_vld  (chain_vld[i+1]),
			.out_pkt  (chain_pkt[i+1])
		);
	end

	// Write-back decision and result
	always_comb begin
		wr         = '0;
		count_nxt  = count_q;
		status_nxt = lkv_pkg::ST_OK;
		found_nxt  = '0;
		unique case (op_q)
			lkv_pkg::OP_ADD: begin
				if (done_q.hit) begin
					status_nxt = lkv_pkg::ST_DUPLICATE;
				end else if (count_q >= lkv_pkg::CNT_W'(lkv_pkg::CAPACITY)) begin
					status_nxt = lkv_pkg::ST_FULL;
				end else begin
					wr.en     = finish;
					wr.slot   = lkv_pkg::IDX_W'(count_q);
					wr.key    = done_q.key;
					wr.val    = add_val_q;
					count_nxt = count_q + lkv_pkg::CNT_W'(1);
				end
			end
			lkv_pkg::OP_GET: begin
				if (done_q.hit) begin
					found_nxt = done_q.hit_val;
				end else begin
					status_nxt = lkv_pkg::ST_NOT_FOUND;
				end
			end
			lkv_pkg::OP_REMOVE: begin
				if (done_q.hit) begin
					found_nxt = done_q.hit_val;
					wr.en     = finish;
					wr.slot   = done_q.slot;
					wr.key    = done_q.last_key;
					wr.val    = done_q.last_val;
					count_nxt = count_q - lkv_pkg::CNT_W'(1);
				end else begin
					status_nxt = lkv_pkg::ST_NOT_FOUND;
				end
			end
			lkv_pkg::OP_NOP: begin
				status_nxt = lkv_pkg::ST_OK;
			end
			default: begin
				status_nxt = lkv_pkg::ST_OK;
			end
		endcase
	end

	// Sequencer, fill count and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// new result loads the slot, else an accepted beat empties it
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_SEARCH;
					end
				end
				S_SEARCH: begin
					if (chain_vld[lkv_pkg::CAPACITY]) begin
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (out_free) begin
						state_q     <= S_IDLE;
						count_q     <= count_nxt;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Request and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q      <= operation;
			add_val_q <= entry_value[lkv_pkg::STORE_W-1:0];
		end
		if (state_q == S_SEARCH && chain_vld[lkv_pkg::CAPACITY]) begin
			done_q <= chain_pkt[lkv_pkg::CAPACITY];
		end
		if (finish) begin
			status_q <= status_nxt;
			found_q  <= found_nxt;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign found_value  = lkv_pkg::VAL_IN_W'(found_q);
	assign entries_used = lkv_pkg::ENTRIES_W'(count_q);

endmodule
`default_nettype wire
